// ----- hdl/asmr_pkg.sv -----
package asmr_pkg;

    localparam int ACC_WIDTH        = 48;
    localparam int IDX_WIDTH        = 28;
    localparam int INNER_SIZE_WIDTH = 13;
    localparam int AXIS_WIDTH       = 16;
    localparam int OUTER_WIDTH      = 16;
    localparam int CFG_ADDR_WIDTH   = 2;
    localparam int CFG_DATA_WIDTH   = 16;
    localparam int DIV_CNT_WIDTH    = $clog2(ACC_WIDTH);
    localparam int CMP_WIDTH        = 17;

    localparam int INNER_MAX_DEF    = 4096;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_INNER_SIZE = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_AXIS_SIZE  = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_OUTER_SIZE = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MEAN_MODE  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

// ----- hdl/axis_sum_mean_reduce_core.sv -----
// Streaming sum / mean reduction over one axis of a row-major tensor that is
// viewed as outer_size x axis_size x inner_size. Samples enter on the
// i_in_valid / o_in_ready channel, one element per transaction. Results leave
// on the o_out_valid / i_out_ready channel, one per completed sum, with the
// flat destination index and a flag on the tensor's last result.
// Configuration goes through the write port (i_cfg_we, i_cfg_addr,
// i_cfg_wdata) while the block is idle; a size of zero acts as one.
// One partial sum per inner position lives in a single-port accumulator
// memory with a registered read. Each element does a read, then an add and
// write-back; the block takes no new element before the write-back and, for
// an element that closes a sum, before the emit step, which loads the output
// register. In mean mode a bit-serial divider runs between the add and emit.
// o_out_valid is registered and rises when the emit step loads a result.
// The output register holds a result while the receiver stalls. The next
// element is still taken, and the block waits only when a second result
// is ready to load. Reset clears the position counters, loads the default
// configuration (all sizes one, sum mode) and empties the output register;
// the memory itself is not cleared, since every sum starts by overwriting
// its entry.
module axis_sum_mean_reduce_core #(
    parameter int INNER_MAX    = asmr_pkg::INNER_MAX_DEF,
    parameter int SAMPLE_WIDTH = asmr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [asmr_pkg::CFG_ADDR_WIDTH-1:0]  i_cfg_addr,
    input  logic [asmr_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [asmr_pkg::ACC_WIDTH-1:0] o_value,
    output logic [asmr_pkg::IDX_WIDTH-1:0]       o_out_index,
    output logic                                 o_tensor_done
);
    import asmr_pkg::*;

    localparam int AW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;

    // Configuration
    logic [INNER_SIZE_WIDTH-1:0] r_inner_size;
    logic [AXIS_WIDTH-1:0]       r_axis_size;
    logic [OUTER_WIDTH-1:0]      r_outer_size;
    logic                        r_mean_mode;

    // Position counters
    logic [AW-1:0]          r_inner_pos;
    logic [AXIS_WIDTH-1:0]  r_axis_pos;
    logic [OUTER_WIDTH-1:0] r_outer_pos;

    t_state r_state, n_state;

    // Captured element
    logic signed [ACC_WIDTH-1:0] r_sample;
    logic                        r_first;
    logic                        r_last_ax;
    logic [AW-1:0]               r_slot;
    logic [IDX_WIDTH-1:0]        r_index;
    logic                        r_done;

    // Accumulator memory
    logic [ACC_WIDTH-1:0] mem_sums [INNER_MAX];
    logic [ACC_WIDTH-1:0] r_rd_data;

    logic signed [ACC_WIDTH-1:0] r_sum;

    // Divider
    logic [ACC_WIDTH-1:0]     r_quo;
    logic [AXIS_WIDTH-1:0]    r_rem;
    logic [DIV_CNT_WIDTH-1:0] r_cnt;
    logic                     r_neg;

    // Output register
    logic                        r_out_valid;
    logic signed [ACC_WIDTH-1:0] r_value;
    logic [IDX_WIDTH-1:0]        r_out_index;
    logic                        r_tensor_done;

    logic                        w_accept;
    logic                        w_mem_we;
    logic                        w_load_out;
    logic                        w_div_last;
    logic [INNER_SIZE_WIDTH-1:0] w_eff_inner;
    logic [INNER_SIZE_WIDTH-1:0] w_n_in;
    logic [AXIS_WIDTH-1:0]       w_n_ax;
    logic [OUTER_WIDTH-1:0]      w_n_out;
    logic                        w_last_in;
    logic                        w_last_ax;
    logic                        w_last_out;
    logic [IDX_WIDTH-1:0]        w_index;
    logic signed [ACC_WIDTH-1:0] w_sample_ext;
    logic signed [ACC_WIDTH-1:0] w_sum;
    logic [ACC_WIDTH-1:0]        w_abs;
    logic [AXIS_WIDTH:0]         w_rem_sh;
    logic [AXIS_WIDTH:0]         w_rem_sub;
    logic                        w_qbit;
    logic signed [ACC_WIDTH-1:0] w_result;

    // Effective sizes: zero acts as one, inner size saturates to the memory depth.
    always_comb begin
        w_eff_inner = (r_inner_size == '0) ? INNER_SIZE_WIDTH'(1) : r_inner_size;
        if (CMP_WIDTH'(w_eff_inner) > CMP_WIDTH'(INNER_MAX)) begin
            w_n_in = INNER_SIZE_WIDTH'(INNER_MAX);
        end else begin
            w_n_in = w_eff_inner;
        end
        w_n_ax  = (r_axis_size == '0) ? AXIS_WIDTH'(1) : r_axis_size;
        w_n_out = (r_outer_size == '0) ? OUTER_WIDTH'(1) : r_outer_size;
    end

    assign w_last_in  = (CMP_WIDTH'(r_inner_pos) + CMP_WIDTH'(1)) >= CMP_WIDTH'(w_n_in);
    assign w_last_ax  = (CMP_WIDTH'(r_axis_pos) + CMP_WIDTH'(1)) >= CMP_WIDTH'(w_n_ax);
    assign w_last_out = (CMP_WIDTH'(r_outer_pos) + CMP_WIDTH'(1)) >= CMP_WIDTH'(w_n_out);

    assign w_index = IDX_WIDTH'(r_outer_pos) * IDX_WIDTH'(w_n_in)
                   + IDX_WIDTH'(r_inner_pos);

    assign w_sample_ext = ACC_WIDTH'(i_sample);
    assign w_sum        = r_first ? r_sample : (r_rd_data + r_sample);
    assign w_abs        = w_sum[ACC_WIDTH-1] ? (-w_sum) : w_sum;

    // One restoring division step per cycle, quotient bits shift in at the bottom.
    assign w_rem_sh   = {r_rem, r_quo[ACC_WIDTH-1]};
    assign w_qbit     = w_rem_sh >= {1'b0, w_n_ax};
    assign w_rem_sub  = w_rem_sh - {1'b0, w_n_ax};
    assign w_div_last = r_cnt == DIV_CNT_WIDTH'(ACC_WIDTH - 1);

    assign w_result = r_mean_mode ? (r_neg ? -r_quo : r_quo) : r_sum;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (!r_last_ax) begin
                    n_state = S_IDLE;
                end else if (r_mean_mode) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                if (w_div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_mem_we   = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_ACC:  w_mem_we   = 1'b1;
            S_DIV:  ;
            S_EMIT: w_load_out = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_inner_size <= INNER_SIZE_WIDTH'(1);
            r_axis_size  <= AXIS_WIDTH'(1);
            r_outer_size <= OUTER_WIDTH'(1);
            r_mean_mode  <= 1'b0;
            r_inner_pos  <= '0;
            r_axis_pos   <= '0;
            r_outer_pos  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_INNER_SIZE: r_inner_size <= i_cfg_wdata[INNER_SIZE_WIDTH-1:0];
                    REG_AXIS_SIZE:  r_axis_size  <= i_cfg_wdata[AXIS_WIDTH-1:0];
                    REG_OUTER_SIZE: r_outer_size <= i_cfg_wdata[OUTER_WIDTH-1:0];
                    REG_MEAN_MODE:  r_mean_mode  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            // A counter at or past its last position wraps on the next advance.
            if (w_accept) begin
                if (!w_last_in) begin
                    r_inner_pos <= r_inner_pos + AW'(1);
                end else begin
                    r_inner_pos <= '0;
                    if (!w_last_ax) begin
                        r_axis_pos <= r_axis_pos + AXIS_WIDTH'(1);
                    end else begin
                        r_axis_pos <= '0;
                        if (!w_last_out) begin
                            r_outer_pos <= r_outer_pos + OUTER_WIDTH'(1);
                        end else begin
                            r_outer_pos <= '0;
                        end
                    end
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample  <= w_sample_ext;
            r_first   <= r_axis_pos == '0;
            r_last_ax <= w_last_ax;
            r_slot    <= r_inner_pos;
            r_index   <= w_index;
            r_done    <= w_last_in && w_last_out;
        end
        if (w_mem_we) begin
            r_sum <= w_sum;
            r_quo <= w_abs;
            r_neg <= w_sum[ACC_WIDTH-1];
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == S_DIV) begin
            r_quo <= {r_quo[ACC_WIDTH-2:0], w_qbit};
            r_rem <= w_qbit ? w_rem_sub[AXIS_WIDTH-1:0] : w_rem_sh[AXIS_WIDTH-1:0];
            r_cnt <= r_cnt + DIV_CNT_WIDTH'(1);
        end
        if (w_load_out) begin
            r_value       <= w_result;
            r_out_index   <= r_index;
            r_tensor_done <= r_done;
        end
    end

    // The read is issued with the transaction and the write-back follows in the
    // next cycle; the next read cannot start before the write, so no
    // forwarding path is needed.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_sums[r_slot] <= w_sum;
        end
        if (w_accept) begin
            r_rd_data <= mem_sums[r_inner_pos];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_out_index   = r_out_index;
    assign o_tensor_done = r_tensor_done;

    a_write_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> $past(w_accept))
        else $error("accumulator write without a preceding transaction");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result appeared outside the emit step");

    a_done_clears_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_done) |=>
            (r_inner_pos == '0 && r_axis_pos == '0 && r_outer_pos == '0))
        else $error("counters not at zero after the tensor's final result");

endmodule

// ----- tb/tb_axis_sum_mean_reduce_core.sv -----
module tb_axis_sum_mean_reduce_core;
    timeunit 1ns;
    timeprecision 1ps;

    import asmr_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int MAX_GAP      = 11;

    typedef struct {
        logic signed [ACC_WIDTH-1:0] value;
        logic [IDX_WIDTH-1:0]        index;
        logic                        done;
    } t_reduced;

    // Tracks the accumulator memory, the position counters and the register
    // file, and queues the reduction of each accepted sample that closes a sum.
    class sum_mean_sb;
        logic signed [ACC_WIDTH-1:0] acc_mem [INNER_MAX_DEF];
        int unsigned inner_pos = 0;
        int unsigned axis_pos  = 0;
        int unsigned outer_pos = 0;

        logic [INNER_SIZE_WIDTH-1:0] reg_inner = 1;
        logic [AXIS_WIDTH-1:0]       reg_axis  = 1;
        logic [OUTER_WIDTH-1:0]      reg_outer = 1;
        logic                        reg_mean  = 1'b0;

        t_reduced    pending [$];
        int unsigned errors       = 0;
        int unsigned samples_seen = 0;
        int unsigned sums_checked = 0;
        int unsigned mean_sums    = 0;

        function int unsigned inner_count(logic [INNER_SIZE_WIDTH-1:0] r);
            if (r == 0)
                return 1;
            return (r > INNER_MAX_DEF) ? INNER_MAX_DEF : r;
        endfunction

        function void write_reg(logic [CFG_ADDR_WIDTH-1:0] addr,
                                logic [CFG_DATA_WIDTH-1:0] data);
            case (addr)
                REG_INNER_SIZE: reg_inner = data[INNER_SIZE_WIDTH-1:0];
                REG_AXIS_SIZE:  reg_axis  = data[AXIS_WIDTH-1:0];
                REG_OUTER_SIZE: reg_outer = data[OUTER_WIDTH-1:0];
                REG_MEAN_MODE:  reg_mean  = data[0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [SAMPLE_WIDTH_DEF-1:0] s);
            int unsigned n_in, n_ax, n_out, slot;
            bit last_in, last_ax, last_out;
            logic signed [ACC_WIDTH-1:0] ext;
            longint v, flat;
            t_reduced want;

            n_in  = inner_count(reg_inner);
            n_ax  = (reg_axis == 0) ? 1 : reg_axis;
            n_out = (reg_outer == 0) ? 1 : reg_outer;
            last_in  = inner_pos + 1 >= n_in;
            last_ax  = axis_pos + 1 >= n_ax;
            last_out = outer_pos + 1 >= n_out;
            slot = (inner_pos < INNER_MAX_DEF) ? inner_pos : INNER_MAX_DEF - 1;
            samples_seen++;

            ext = s;
            if (axis_pos == 0)
                acc_mem[slot] = ext;
            else
                acc_mem[slot] = acc_mem[slot] + ext;

            if (last_ax) begin
                v = acc_mem[slot];
                if (reg_mean) begin
                    // Signed division truncates toward zero, as the block does.
                    v = v / longint'(n_ax);
                    mean_sums++;
                end
                flat = longint'(outer_pos) * longint'(n_in) + longint'(inner_pos);
                want.value = v[ACC_WIDTH-1:0];
                want.index = flat[IDX_WIDTH-1:0];
                want.done  = last_in && last_out;
                pending.push_back(want);
            end

            if (!last_in) begin
                inner_pos++;
            end else begin
                inner_pos = 0;
                if (!last_ax) begin
                    axis_pos++;
                end else begin
                    axis_pos = 0;
                    outer_pos = last_out ? 0 : outer_pos + 1;
                end
            end
        endfunction

        function void check_result(logic signed [ACC_WIDTH-1:0] value,
                                   logic [IDX_WIDTH-1:0] index, logic done);
            t_reduced want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, got value %0d index %0d",
                         $time, value, index);
                errors++;
                return;
            end
            want = pending.pop_front();
            sums_checked++;
            if (value !== want.value) begin
                $display("%0t: value mismatch, expected %0d, got %0d",
                         $time, want.value, value);
                errors++;
            end
            if (index !== want.index) begin
                $display("%0t: index mismatch, expected %0d, got %0d",
                         $time, want.index, index);
                errors++;
            end
            if (done !== want.done) begin
                $display("%0t: tensor_done mismatch, expected %0b, got %0b",
                         $time, want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n     = 1'b0;
    logic                                i_cfg_we    = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0]           i_cfg_addr  = REG_INNER_SIZE;
    logic [CFG_DATA_WIDTH-1:0]           i_cfg_wdata = '0;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_ready;
    logic signed [SAMPLE_WIDTH_DEF-1:0]  i_sample    = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic signed [ACC_WIDTH-1:0]         o_value;
    logic [IDX_WIDTH-1:0]                o_out_index;
    logic                                o_tensor_done;

    axis_sum_mean_reduce_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_out_index   (o_out_index),
        .o_tensor_done (o_tensor_done)
    );

    sum_mean_sb  sb = new;
    int unsigned tx_gap      = 0;
    bit          tx_calm     = 1'b0;
    bit          rx_calm     = 1'b0;
    int unsigned random_sent = 0;
    int unsigned cfg_writes  = 0;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side: takes each result, then holds ready low for a random stall.
    initial begin
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                sb.check_result(o_value, o_out_index, o_tensor_done);
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic [CFG_ADDR_WIDTH-1:0] addr,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(addr, data);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // Valid stays up across back-to-back transactions when more follow with
    // no gap, so it is never lowered and raised in the same step.
    task automatic send_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] s,
                               input bit more);
        repeat (tx_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_sample(s);
        tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (!more || tx_gap != 0)
            i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return 32'(int'($urandom_range(0, 64)) - 32);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_burst(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_sample(pick_sample(), i + 1 < n);
            random_sent++;
        end
    endtask

    task automatic random_phase();
        int unsigned pick, count;
        longint span;
        logic [INNER_SIZE_WIDTH-1:0] inner_v;
        logic [AXIS_WIDTH-1:0] axis_v;
        logic [OUTER_WIDTH-1:0] outer_v;
        bit wrote;

        pick = $urandom_range(0, 19);
        inner_v = (pick == 0) ? 13'd0 :
                  (pick == 1) ? 13'($urandom_range(7, 8191)) :
                  13'($urandom_range(1, 6));
        pick = $urandom_range(0, 19);
        axis_v = (pick == 0) ? 16'd0 :
                 (pick == 1) ? 16'hFFFF :
                 (pick == 2) ? 16'($urandom) :
                 16'($urandom_range(1, 6));
        pick = $urandom_range(0, 19);
        outer_v = (pick == 0) ? 16'd0 :
                  (pick == 1) ? 16'hFFFF :
                  16'($urandom_range(1, 3));

        wrote = 1'b0;
        // Within a sum, inner_size may only shrink: a larger row would read
        // accumulator slots that hold nothing yet.
        if ($urandom_range(0, 1) && (sb.axis_pos == 0 ||
                sb.inner_count(inner_v) <= sb.inner_count(sb.reg_inner))) begin
            cfg_write(REG_INNER_SIZE, {3'($urandom), inner_v});
            wrote = 1'b1;
        end
        if ($urandom_range(0, 1)) begin
            cfg_write(REG_AXIS_SIZE, axis_v);
            wrote = 1'b1;
        end
        if ($urandom_range(0, 1)) begin
            cfg_write(REG_OUTER_SIZE, outer_v);
            wrote = 1'b1;
        end
        if (!wrote || $urandom_range(0, 1))
            cfg_write(REG_MEAN_MODE, {15'($urandom), 1'($urandom)});

        span = longint'(sb.inner_count(sb.reg_inner)) *
               longint'((sb.reg_axis == 0) ? 1 : sb.reg_axis) *
               longint'((sb.reg_outer == 0) ? 1 : sb.reg_outer);
        span = 2 * span + 2;
        count = $urandom_range(1, (span > 160) ? 160 : int'(span));
        tx_calm = ($urandom_range(0, 3) == 0);
        send_burst(count);
        wait_idle();
    endtask

    initial begin
        logic signed [SAMPLE_WIDTH_DEF-1:0] extreme_vals [5];
        logic signed [SAMPLE_WIDTH_DEF-1:0] mean_vals [8];

        extreme_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1};
        // Row-major 2 x 2 x 2: a negative odd sum, the largest sum, the most negative
        // sum, and a positive odd sum, all divided by two.
        mean_vals = '{-32'sd3, 32'sh7FFF_FFFF, 32'sd0, 32'sh7FFF_FFFF,
                      32'sh8000_0000, 32'sd5, 32'sh8000_0000, 32'sd2};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default configuration: every sample is its own one-element sum.
        foreach (extreme_vals[i])
            send_sample(extreme_vals[i], i < 4);
        wait_idle();

        cfg_write(REG_INNER_SIZE, 16'd2);
        cfg_write(REG_AXIS_SIZE, 16'd2);
        cfg_write(REG_OUTER_SIZE, 16'd2);
        cfg_write(REG_MEAN_MODE, 16'd1);
        foreach (mean_vals[i])
            send_sample(mean_vals[i], i < 7);
        wait_idle();

        // Zero sizes behave as one.
        cfg_write(REG_INNER_SIZE, 16'd0);
        cfg_write(REG_AXIS_SIZE, 16'd0);
        cfg_write(REG_OUTER_SIZE, 16'd0);
        cfg_write(REG_MEAN_MODE, 16'd0);
        send_sample(-32'sd12345, 1'b1);
        send_sample(32'sd67890, 1'b0);
        wait_idle();

        while (random_sent < RANDOM_ITEMS)
            random_phase();
        wait_idle();

        $display("Run covered %0d samples and %0d register writes, including saturated,",
                 sb.samples_seen, cfg_writes);
        $display("zero and mid-tensor sizes; %0d results checked, %0d of them means, %0d errors.",
                 sb.sums_checked, sb.mean_sums, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- axis_sum_mean_reduce_core.f -----
hdl/asmr_pkg.sv
hdl/axis_sum_mean_reduce_core.sv
tb/tb_axis_sum_mean_reduce_core.sv
